// ===== design/tdbs_pkg.sv =====
// ----------------------------------------------------------------------------
// tdbs_pkg: shared types and constants for the trial division block search
// Widths, register codes, result codes and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package tdbs_pkg;

  // Sizing
  localparam int CANDIDATE_WIDTH = 32;  // 8..32
  localparam int MODULUS_WIDTH   = 64;  // 16..64
  localparam int BIT_CNT_W       = $clog2(MODULUS_WIDTH);
  localparam int BLOCK_BITS_W    = 6;
  localparam int CFG_INDEX_W     = 8;
  localparam int CFG_DATA_W      = 64;
  localparam int ADDR_W          = 32;
  localparam int FACTOR_W        = 32;
  localparam int STATUS_W        = 2;

  // Register reset values
  localparam logic [MODULUS_WIDTH-1:0] MODULUS_RST    = MODULUS_WIDTH'(1);
  localparam logic [BLOCK_BITS_W-1:0]  BLOCK_BITS_RST = BLOCK_BITS_W'(16);

  // Register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MODULUS    = 8'd0,
    CFG_BLOCK_BITS = 8'd1
  } cfg_index_e;

  // Result codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_NONE  = 2'd0,
    STAT_FOUND = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_TEST,
    ST_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic    capture;    // latch the block address
    logic    init;       // set up first candidate, clear remainder
    logic    div_step;   // one remainder bit
    logic    next_cand;  // advance by two, clear remainder
    logic    set_res;    // record the pending result code
    status_e res;
    logic    load_out;   // move pending result to the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_of_range;
    logic last_bit;
    logic divides;       // remainder zero and candidate is not one
    logic cand_is_last;
    logic out_free;
  } stat_t;

endpackage

// ===== design/tdbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// tdbs_ctrl: sequencer for the block search
// Steps through range check, one remainder pass per candidate and result.
// ----------------------------------------------------------------------------
module tdbs_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tdbs_pkg::stat_t stat_i,
  output tdbs_pkg::cmd_t  cmd_o
);

  tdbs_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tdbs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tdbs_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = tdbs_pkg::ST_CHECK;
      end
      tdbs_pkg::ST_CHECK: begin
        state_d = stat_i.out_of_range ? tdbs_pkg::ST_DONE : tdbs_pkg::ST_DIV;
      end
      tdbs_pkg::ST_DIV: begin
        if (stat_i.last_bit) state_d = tdbs_pkg::ST_TEST;
      end
      tdbs_pkg::ST_TEST: begin
        if (stat_i.divides || stat_i.cand_is_last) begin
          state_d = tdbs_pkg::ST_DONE;
        end else begin
          state_d = tdbs_pkg::ST_DIV;
        end
      end
      tdbs_pkg::ST_DONE: begin
        if (stat_i.out_free) state_d = tdbs_pkg::ST_IDLE;
      end
      default: state_d = tdbs_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.res  = tdbs_pkg::STAT_NONE;
    case (state_q)
      tdbs_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      tdbs_pkg::ST_CHECK: begin
        if (stat_i.out_of_range) begin
          cmd_o.set_res = 1'b1;
          cmd_o.res     = tdbs_pkg::STAT_RANGE;
        end else begin
          cmd_o.init = 1'b1;
        end
      end
      tdbs_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      tdbs_pkg::ST_TEST: begin
        if (stat_i.divides) begin
          cmd_o.set_res = 1'b1;
          cmd_o.res     = tdbs_pkg::STAT_FOUND;
        end else if (stat_i.cand_is_last) begin
          cmd_o.set_res = 1'b1;
          cmd_o.res     = tdbs_pkg::STAT_NONE;
        end else begin
          cmd_o.next_cand = 1'b1;
        end
      end
      tdbs_pkg::ST_DONE: begin
        cmd_o.load_out = stat_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // A remainder pass always ends in a candidate test
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tdbs_pkg::ST_DIV) && stat_i.last_bit |=> (state_q == tdbs_pkg::ST_TEST))
    else $error("remainder pass did not end in a test");

  // Setting a result code always leads to completion
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.set_res |=> (state_q == tdbs_pkg::ST_DONE))
    else $error("result code set outside of completion");

  // No new request during a remainder pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tdbs_pkg::ST_DIV) |-> !in_ready_o)
    else $error("input ready during remainder pass");

endmodule

// ===== design/tdbs_dp.sv =====
// ----------------------------------------------------------------------------
// tdbs_dp: datapath for the block search
// Config registers, candidate range, bit-serial remainder and output register.
// ----------------------------------------------------------------------------
module tdbs_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration writes
  input  logic                                 cfg_we_i,
  input  logic [tdbs_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [tdbs_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // request payload
  input  logic [tdbs_pkg::ADDR_W-1:0]          addr_i,
  // control
  input  tdbs_pkg::cmd_t                       cmd_i,
  output tdbs_pkg::stat_t                      stat_o,
  // result channel
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic [tdbs_pkg::STATUS_W-1:0]        out_status_o,
  output logic [tdbs_pkg::FACTOR_W-1:0]        out_factor_o
);

  localparam int CW  = tdbs_pkg::CANDIDATE_WIDTH;
  localparam int MW  = tdbs_pkg::MODULUS_WIDTH;
  localparam int BCW = tdbs_pkg::BIT_CNT_W;
  localparam int BBW = tdbs_pkg::BLOCK_BITS_W;
  localparam logic [BBW-1:0] CW_B   = BBW'(CW);
  localparam logic [BCW-1:0] TOP_BIT = BCW'(MW - 1);

  logic [MW-1:0]                   modulus_q;
  logic [BBW-1:0]                  block_bits_q;
  logic [tdbs_pkg::ADDR_W-1:0]     addr_q;
  logic [CW-1:0]                   cand_q, last_q, rem_q;
  logic [BCW-1:0]                  bit_cnt_q;
  tdbs_pkg::status_e               res_q;
  logic                            out_valid_q;
  logic [tdbs_pkg::STATUS_W-1:0]   out_status_q;
  logic [tdbs_pkg::FACTOR_W-1:0]   out_factor_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q    <= tdbs_pkg::MODULUS_RST;
      block_bits_q <= tdbs_pkg::BLOCK_BITS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tdbs_pkg::CFG_MODULUS:    modulus_q    <= cfg_data_i[MW-1:0];
        tdbs_pkg::CFG_BLOCK_BITS: block_bits_q <= cfg_data_i[BBW-1:0];
        default: ;
      endcase
    end
  end

  // Range check and candidate bounds
  logic [BBW-1:0] b_eff, shamt;
  logic [CW-1:0]  base_w;
  logic [CW-1:0]  span;
  logic           out_of_range;

  always_comb begin
    b_eff        = (block_bits_q == '0) ? BBW'(1) : block_bits_q;
    shamt        = CW_B - b_eff;
    out_of_range = (b_eff > CW_B) || ((addr_q >> shamt) != '0);
    base_w       = CW'(addr_q) << b_eff;
    span         = ~({CW{1'b1}} << b_eff);
  end

  // Remainder step: shift in the next modulus bit, subtract if it fits
  logic [CW:0]   shifted, diff;
  logic [CW-1:0] rem_next;

  always_comb begin
    shifted  = {rem_q, modulus_q[bit_cnt_q]};
    diff     = shifted - {1'b0, cand_q};
    rem_next = diff[CW] ? shifted[CW-1:0] : diff[CW-1:0];
  end

  // Search registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) addr_q <= addr_i;
    if (cmd_i.init) begin
      cand_q    <= base_w | CW'(1);
      last_q    <= base_w | span;
      rem_q     <= '0;
      bit_cnt_q <= TOP_BIT;
    end else if (cmd_i.next_cand) begin
      cand_q    <= cand_q + CW'(2);
      rem_q     <= '0;
      bit_cnt_q <= TOP_BIT;
    end else if (cmd_i.div_step) begin
      rem_q     <= rem_next;
      bit_cnt_q <= bit_cnt_q - BCW'(1);
    end
    if (cmd_i.set_res) res_q <= cmd_i.res;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_status_q <= res_q;
      out_factor_q <= (res_q == tdbs_pkg::STAT_FOUND) ? tdbs_pkg::FACTOR_W'(cand_q) : '0;
    end
  end

  // Status back to the controller
  always_comb begin
    stat_o.out_of_range = out_of_range;
    stat_o.last_bit     = (bit_cnt_q == '0);
    stat_o.divides      = (rem_q == '0) && (cand_q != CW'(1));
    stat_o.cand_is_last = (cand_q == last_q);
    stat_o.out_free     = !out_valid_q || out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_factor_o = out_factor_q;

  // Reported factor is an odd candidate above one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_status_q == tdbs_pkg::STAT_FOUND)
      |-> (out_factor_q[0] && (out_factor_q != tdbs_pkg::FACTOR_W'(1))))
    else $error("reported factor is not a valid candidate");

  // Factor is zero unless a divisor was found
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_status_q != tdbs_pkg::STAT_FOUND) |-> (out_factor_q == '0))
    else $error("nonzero factor without a divisor");

  // Loading never overwrites a result that has not been taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || out_ready_i))
    else $error("pending result overwritten");

endmodule

// ===== design/trial_division_block_search.sv =====
// ----------------------------------------------------------------------------
// trial_division_block_search: trial division over one block of candidates
// Searches the odd numbers of a block for the first divisor of the modulus.
// ----------------------------------------------------------------------------
//  channel  direction  signals                     content
//  s_axis   in         tvalid/tready/tdata[31:0]   block_address
//  m_axis   out        tvalid/tready/tdata[31:0]   factor
//                      tuser[1:0]                  status
//  cfg      in         valid/ready/index/data      register writes
//
//  Each candidate takes a remainder pass, one remainder bit per cycle in the
//  bit-serial divider, and then a test state. The search tests up to
//  2^(b-1) candidates; an out-of-range block goes from the range check
//  straight to completion.
//  The next request is accepted in the cycle after the result is loaded.
//  Reset is asynchronous, active low, and restores modulus 1 and block_bits 16.
//  A stalled result waits in the output register while the next request is
//  accepted; it completes only once the result has been taken.
module trial_division_block_search (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [tdbs_pkg::ADDR_W-1:0]      s_axis_tdata,  // [31:0] block_address
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [tdbs_pkg::FACTOR_W-1:0]    m_axis_tdata,  // [31:0] factor
  output logic [tdbs_pkg::STATUS_W-1:0]    m_axis_tuser,  // [1:0] status
  // configuration writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tdbs_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [tdbs_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  tdbs_pkg::cmd_t  cmd;
  tdbs_pkg::stat_t stat;

  // Writes must only arrive while idle; the block leaves this to the user
  assign cfg_ready_o = 1'b1;

  tdbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tdbs_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i & cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .addr_i       (s_axis_tdata),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (m_axis_tuser),
    .out_factor_o (m_axis_tdata)
  );

endmodule

// ===== verif/trial_division_block_search_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trial_division_block_search_tb: self-checking bench for the block search
// A queue-fed driver sends block addresses and a monitor checks every result
// against a local trial-division predictor, across several register settings
// and idle/stall mixes on both streams.
// ----------------------------------------------------------------------------
module trial_division_block_search_tb;

  localparam int WATCHDOG_LIMIT = 100000;  // cycles without any handshake
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 100;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 10;
  localparam logic [tdbs_pkg::CFG_INDEX_W-1:0] CFG_UNMAPPED = tdbs_pkg::CFG_INDEX_W'(2);

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef enum int {
    MOD_ZERO,
    MOD_RANDOM,
    MOD_WIDE_PAIR,
    MOD_SMALL_FACTOR
  } modulus_style_e;

  typedef struct packed {
    tdbs_pkg::status_e                status;
    logic [tdbs_pkg::FACTOR_W-1:0]    factor;
  } search_result_t;

  // DUT inputs, all driven to known values from time zero
  logic                             clk_i         = 1'b0;
  logic                             rst_ni        = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [tdbs_pkg::ADDR_W-1:0]      s_axis_tdata  = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [tdbs_pkg::FACTOR_W-1:0]    m_axis_tdata;
  logic [tdbs_pkg::STATUS_W-1:0]    m_axis_tuser;
  logic                             cfg_valid_i   = 1'b0;
  logic                             cfg_ready_o;
  logic [tdbs_pkg::CFG_INDEX_W-1:0] cfg_index_i   = '0;
  logic [tdbs_pkg::CFG_DATA_W-1:0]  cfg_data_i    = '0;

  // Shadow registers, reset values as in the block
  logic [tdbs_pkg::MODULUS_WIDTH-1:0] modulus_q    = tdbs_pkg::MODULUS_RST;
  logic [tdbs_pkg::BLOCK_BITS_W-1:0]  block_bits_q = tdbs_pkg::BLOCK_BITS_RST;

  logic [tdbs_pkg::ADDR_W-1:0]  block_addr_q[$];      // addresses waiting to be sent
  search_result_t               search_results_q[$];  // predicted results, oldest first
  search_result_t               oldest_result;
  logic                         req_taken = 1'b0;
  int                           sender_idle_pct  = 0;
  int                           receiver_stall_pct = 0;
  int                           mismatch_count = 0;
  int                           quiet_cycles = 0;

  trial_division_block_search u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [31:0] block_address
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [31:0] factor
    .m_axis_tuser  (m_axis_tuser),   // [1:0] status
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Trial division over one block: first odd divisor, skipping one
  function automatic search_result_t search_block(
    input logic [tdbs_pkg::ADDR_W-1:0]        addr,
    input logic [tdbs_pkg::MODULUS_WIDTH-1:0] modulus,
    input logic [tdbs_pkg::BLOCK_BITS_W-1:0]  bb
  );
    search_result_t res;
    int unsigned    b;
    logic [63:0]    m;
    logic [63:0]    cand;
    logic [63:0]    last;
    res.status = tdbs_pkg::STAT_NONE;
    res.factor = '0;
    m = 64'(modulus);
    b = (bb == 0) ? 1 : int'(bb);
    if (b > tdbs_pkg::CANDIDATE_WIDTH) begin
      res.status = tdbs_pkg::STAT_RANGE;
      return res;
    end
    if (64'(addr) >= (64'd1 << (tdbs_pkg::CANDIDATE_WIDTH - b))) begin
      res.status = tdbs_pkg::STAT_RANGE;
      return res;
    end
    cand = (64'(addr) << b) + 64'd1;
    last = cand + (64'd1 << b) - 64'd2;
    while (cand <= last) begin
      if (cand != 64'd1 && (m % cand) == 64'd0) begin
        res.status = tdbs_pkg::STAT_FOUND;
        res.factor = cand[tdbs_pkg::FACTOR_W-1:0];
        return res;
      end
      cand += 64'd2;
    end
    return res;
  endfunction

  // Request driver: hold until taken, then next address or an idle cycle
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || req_taken) begin
        if (block_addr_q.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
          s_axis_tdata  <= block_addr_q.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99, 0) >= receiver_stall_pct);
    end
  end

  // Monitor: predict on each accepted request, check each accepted result
  always @(posedge clk_i) begin
    if (rst_ni) begin
      req_taken <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        if (search_results_q.size() == 0) begin
          $display("%0t: unexpected result status %0d factor %08h", $time,
                   m_axis_tuser, m_axis_tdata);
          mismatch_count++;
        end else begin
          oldest_result = search_results_q.pop_front();
          if (m_axis_tuser !== oldest_result.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                     oldest_result.status, m_axis_tuser);
            mismatch_count++;
          end
          if (m_axis_tdata !== oldest_result.factor) begin
            $display("%0t: factor mismatch, expected %08h, actual %08h", $time,
                     oldest_result.factor, m_axis_tdata);
            mismatch_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        search_results_q.push_back(search_block(s_axis_tdata, modulus_q, block_bits_q));
    end
  end

  // Watchdog: too long with no handshake on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Wait until every address is sent and every result is back
  task automatic settle();
    do @(posedge clk_i);
    while (block_addr_q.size() != 0 || s_axis_tvalid || search_results_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One register write; shadow copy follows on acceptance
  task automatic write_reg(input logic [tdbs_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [tdbs_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    case (idx)
      tdbs_pkg::CFG_MODULUS:    modulus_q    = data[tdbs_pkg::MODULUS_WIDTH-1:0];
      tdbs_pkg::CFG_BLOCK_BITS: block_bits_q = data[tdbs_pkg::BLOCK_BITS_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Block size word with junk in the unused upper bits
  function automatic logic [tdbs_pkg::CFG_DATA_W-1:0] bb_word(
    input logic [tdbs_pkg::BLOCK_BITS_W-1:0] b
  );
    logic [tdbs_pkg::CFG_DATA_W-1:0] w;
    w = {$urandom, $urandom};
    w[tdbs_pkg::BLOCK_BITS_W-1:0] = b;
    return w;
  endfunction

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE:     begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      IDLE_SENDER:   begin sender_idle_pct = 53; receiver_stall_pct = 0;  end
      IDLE_RECEIVER: begin sender_idle_pct = 0;  receiver_stall_pct = 53; end
      default:       begin sender_idle_pct = 8;  receiver_stall_pct = 8;  end
    endcase
  endtask

  // Stimulus sequence and final verdict
  initial begin
    logic [31:0]    p;
    logic [31:0]    q;
    logic [63:0]    mod;
    logic [32:0]    limit;
    int             b;
    int             pick;
    modulus_style_e style;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: block size 16, only refused blocks (modulus 1 is slow)
    set_idling(IDLE_NONE);
    block_addr_q.push_back(32'h0001_0000);
    block_addr_q.push_back(32'hFFFF_FFFF);
    settle();

    // Modulus zero, block size zero acts as one: candidate one is skipped
    write_reg(tdbs_pkg::CFG_MODULUS, 64'd0);
    write_reg(tdbs_pkg::CFG_BLOCK_BITS, bb_word(6'd0));
    block_addr_q.push_back(32'h0000_0000);
    block_addr_q.push_back(32'h0000_0001);
    block_addr_q.push_back(32'h7FFF_FFFF);
    block_addr_q.push_back(32'h8000_0000);
    settle();

    // Widest block: only block zero fits
    set_idling(IDLE_BOTH);
    write_reg(tdbs_pkg::CFG_MODULUS, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(tdbs_pkg::CFG_BLOCK_BITS, bb_word(6'd32));
    block_addr_q.push_back(32'h0000_0000);
    block_addr_q.push_back(32'h0000_0001);
    block_addr_q.push_back(32'hFFFF_FFFF);
    settle();

    // Block size beyond the candidate width
    write_reg(tdbs_pkg::CFG_BLOCK_BITS, bb_word(6'd33));
    block_addr_q.push_back(32'h0000_0000);
    settle();
    write_reg(tdbs_pkg::CFG_BLOCK_BITS, bb_word(6'd63));
    block_addr_q.push_back(32'h0000_0000);
    settle();

    // Top candidates with block size one
    set_idling(IDLE_NONE);
    write_reg(tdbs_pkg::CFG_MODULUS, 64'h0000_0000_FFFF_FFFF * 64'h0000_0000_FFFF_FFFB);
    write_reg(tdbs_pkg::CFG_BLOCK_BITS, bb_word(6'd1));
    block_addr_q.push_back(32'h7FFF_FFFF);
    block_addr_q.push_back(32'h7FFF_FFFD);
    block_addr_q.push_back(32'h7FFF_FFFE);
    settle();

    // Two large primes: nothing in block zero, hit in the last block
    write_reg(tdbs_pkg::CFG_MODULUS, 64'h0000_0000_FFFF_FFFB * 64'h0000_0000_FFFF_FFEF);
    write_reg(tdbs_pkg::CFG_BLOCK_BITS, bb_word(6'd8));
    block_addr_q.push_back(32'h0000_0000);
    block_addr_q.push_back(32'h00FF_FFFF);
    block_addr_q.push_back(32'h0100_0000);
    settle();

    // Large blocks against modulus zero: first candidate divides, or the block is refused
    write_reg(tdbs_pkg::CFG_MODULUS, 64'd0);
    write_reg(tdbs_pkg::CFG_BLOCK_BITS, bb_word(6'd20));
    block_addr_q.push_back(32'h0000_0005);
    settle();
    write_reg(tdbs_pkg::CFG_BLOCK_BITS, bb_word(6'd31));
    block_addr_q.push_back(32'h0000_0001);
    block_addr_q.push_back(32'h0000_0002);
    settle();

    // Write to an unmapped index leaves both registers alone
    write_reg(CFG_UNMAPPED, {$urandom, $urandom});
    block_addr_q.push_back(32'h0000_0000);
    settle();

    // Random phases: small blocks, moduli zero, random or with planted factors
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      set_idling(idle_mode_e'(ph % 4));
      pick = $urandom_range(9, 0);
      if (pick == 0)      style = MOD_ZERO;
      else if (pick < 3)  style = MOD_RANDOM;
      else if (pick < 7)  style = MOD_WIDE_PAIR;
      else                style = MOD_SMALL_FACTOR;
      p = $urandom | 32'd1;
      q = $urandom | 32'd1;
      case (style)
        MOD_ZERO:      mod = 64'd0;
        MOD_RANDOM:    mod = {$urandom, $urandom};
        MOD_WIDE_PAIR: mod = 64'(p) * 64'(q);
        default: begin
          p   = $urandom_range(255, 3) | 32'd1;
          mod = 64'(p) * ({$urandom, $urandom} & 64'h00FF_FFFF_FFFF_FFFF);
        end
      endcase
      b = $urandom_range(7, 1);
      limit = 33'd1 << (tdbs_pkg::CANDIDATE_WIDTH - b);
      write_reg(tdbs_pkg::CFG_MODULUS, mod);
      write_reg(tdbs_pkg::CFG_BLOCK_BITS, bb_word(tdbs_pkg::BLOCK_BITS_W'(b)));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(99, 0);
        if (pick < 45)
          block_addr_q.push_back(p >> b);
        else if (pick < 60)
          block_addr_q.push_back(q >> b);
        else if (pick < 75)
          block_addr_q.push_back($urandom_range(32'hFFFF_FFFF, 32'(limit)));
        else
          block_addr_q.push_back($urandom & 32'(limit - 33'd1));
      end
      settle();
    end

    // Drain, then watch for stray results
    repeat (TAIL_CYCLES) @(posedge clk_i);
    mismatch_count += search_results_q.size();
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
